### rtl/segment_triangle_intersect_assert.svh
// Assertion macros shared by the intersection pipeline.
`ifndef SEGMENT_TRIANGLE_INTERSECT_ASSERT_SVH
`define SEGMENT_TRIANGLE_INTERSECT_ASSERT_SVH
// An implication checked on every rising clock edge outside reset.
`define STI_ASSERT_IMPLY(label, clk, rst, cond, prop, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (cond) |-> (prop)) \
      else $error(msg);
// An implication checked in the cycle after its trigger.
`define STI_ASSERT_NEXT(label, clk, rst, cond, prop, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (cond) |=> (prop)) \
      else $error(msg);
`endif

### rtl/sti_pkg.sv
// Package with the types and constants of the segment/triangle intersection block.
`default_nettype none
package sti_pkg;
   localparam int COORD_BITS    = 24;
   localparam int FRAC_OUT_BITS = 16;
   localparam int FRAC_W        = FRAC_OUT_BITS + 1;
   localparam int DIFF_BITS     = COORD_BITS + 1;
   localparam int PROD_BITS     = 2 * DIFF_BITS;
   localparam int CROSS_BITS    = PROD_BITS + 1;
   localparam int TERM_BITS     = CROSS_BITS + DIFF_BITS;
   localparam int DOT_BITS      = TERM_BITS + 2;
   localparam int REM_BITS      = DOT_BITS + 1;
   // A cross component is multiplied as an unsigned low half and a signed high half.
   localparam int LO_BITS       = DIFF_BITS;
   localparam int HI_BITS       = CROSS_BITS - LO_BITS;
   localparam int PART_BITS     = DIFF_BITS + LO_BITS + 1;

   localparam logic [2:0] CSR_START_X = 3'd0;
   localparam logic [2:0] CSR_START_Y = 3'd1;
   localparam logic [2:0] CSR_START_Z = 3'd2;
   localparam logic [2:0] CSR_END_X   = 3'd3;
   localparam logic [2:0] CSR_END_Y   = 3'd4;
   localparam logic [2:0] CSR_END_Z   = 3'd5;

   localparam logic [1:0] CAUSE_HIT      = 2'd0;
   localparam logic [1:0] CAUSE_BACKFACE = 2'd1;
   localparam logic [1:0] CAUSE_PLANE    = 2'd2;
   localparam logic [1:0] CAUSE_OUTSIDE  = 2'd3;

   typedef struct packed {
      logic signed [COORD_BITS-1:0] vert_a_x;
      logic signed [COORD_BITS-1:0] vert_a_y;
      logic signed [COORD_BITS-1:0] vert_a_z;
      logic signed [COORD_BITS-1:0] vert_b_x;
      logic signed [COORD_BITS-1:0] vert_b_y;
      logic signed [COORD_BITS-1:0] vert_b_z;
      logic signed [COORD_BITS-1:0] vert_c_x;
      logic signed [COORD_BITS-1:0] vert_c_y;
      logic signed [COORD_BITS-1:0] vert_c_z;
   } req_type;

   typedef struct packed {
      logic              hit;
      logic [FRAC_W-1:0] hit_fraction;
      logic [1:0]        miss_cause;
   } rsp_type;

   // One step of the restoring divider travels between stages as this struct.
   typedef struct packed {
      logic                       valid;
      logic                       hit;
      logic [1:0]                 cause;
      logic [FRAC_W-1:0]          quot;
      logic signed [REM_BITS-1:0] rem;
      logic signed [DOT_BITS-1:0] den;
   } div_stage_type;
endpackage
`default_nettype wire

### rtl/segment_triangle_intersect.sv
// Top level of the one-sided segment/triangle intersection pipeline.
// Each start beat reaches rsp_valid through the front-end stages and then the divider.
// Throughput: one triangle per cycle; busy is always low, the pipeline never stalls.
// The divider stages, one per quotient bit, set the depth.
// Synchronous active-high reset empties the pipeline and clears the segment registers.
// The receiver cannot stall; each result is shown for exactly one cycle.
`default_nettype none
`include "segment_triangle_intersect_assert.svh"
module segment_triangle_intersect
   import sti_pkg::*;
(
   input  wire                   clock,
   input  wire                   reset,
   input  wire                   start,
   output logic                  busy,
   input  wire req_type          req_data,
   output logic                  rsp_valid,
   output rsp_type               rsp_data,
   input  wire                   csr_valid,
   output logic                  csr_ready,
   input  wire [2:0]             csr_index,
   input  wire [COORD_BITS-1:0]  csr_wdata
);
   typedef logic signed [DIFF_BITS-1:0]  diff_type;
   typedef logic signed [PROD_BITS-1:0]  prod_type;
   typedef logic signed [CROSS_BITS-1:0] cross_type;
   typedef logic signed [PART_BITS-1:0]  part_type;
   typedef logic signed [TERM_BITS-1:0]  term_type;
   typedef logic signed [DOT_BITS-1:0]   dot_type;

   // Segment registers (CSR); user writes only while the pipeline idles, not enforced.
   logic signed [COORD_BITS-1:0] seg_ff [6];

   assign csr_ready = 1'b1;
   assign busy      = 1'b0;

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < 6; i++) seg_ff[i] <= '0;
      end else if (csr_valid && csr_ready) begin
         unique case (csr_index)
            CSR_START_X: seg_ff[0] <= csr_wdata;
            CSR_START_Y: seg_ff[1] <= csr_wdata;
            CSR_START_Z: seg_ff[2] <= csr_wdata;
            CSR_END_X:   seg_ff[3] <= csr_wdata;
            CSR_END_Y:   seg_ff[4] <= csr_wdata;
            CSR_END_Z:   seg_ff[5] <= csr_wdata;
            default: ;
         endcase
      end
   end

   // Stage 1: edge vectors ab, ac, the segment vector qp = S - Q and ap = S - A.
   logic     v1_ff;
   diff_type ab_ff [3], ac_ff [3], qp_ff [3], ap_ff [3];
   logic signed [COORD_BITS-1:0] va [3], vb [3], vc [3];
   assign va = '{req_data.vert_a_x, req_data.vert_a_y, req_data.vert_a_z};
   assign vb = '{req_data.vert_b_x, req_data.vert_b_y, req_data.vert_b_z};
   assign vc = '{req_data.vert_c_x, req_data.vert_c_y, req_data.vert_c_z};

   always_ff @(posedge clock) begin
      v1_ff <= reset ? 1'b0 : (start && !busy);
      for (int k = 0; k < 3; k++) begin
         ab_ff[k] <= DIFF_BITS'(vb[k]) - DIFF_BITS'(va[k]);
         ac_ff[k] <= DIFF_BITS'(vc[k]) - DIFF_BITS'(va[k]);
         qp_ff[k] <= DIFF_BITS'(seg_ff[k]) - DIFF_BITS'(seg_ff[3+k]);
         ap_ff[k] <= DIFF_BITS'(seg_ff[k]) - DIFF_BITS'(va[k]);
      end
   end

   // Stage 2: the products of both cross products n = ab x ac and e = qp x ap.
   logic     v2_ff;
   prod_type np_ff [6], ep_ff [6];
   diff_type ab2_ff [3], ac2_ff [3], qp2_ff [3], ap2_ff [3];
   always_ff @(posedge clock) begin
      v2_ff <= reset ? 1'b0 : v1_ff;
      for (int k = 0; k < 3; k++) begin
         np_ff[2*k]   <= PROD_BITS'(ab_ff[(k+1)%3]) * PROD_BITS'(ac_ff[(k+2)%3]);
         np_ff[2*k+1] <= PROD_BITS'(ab_ff[(k+2)%3]) * PROD_BITS'(ac_ff[(k+1)%3]);
         ep_ff[2*k]   <= PROD_BITS'(qp_ff[(k+1)%3]) * PROD_BITS'(ap_ff[(k+2)%3]);
         ep_ff[2*k+1] <= PROD_BITS'(qp_ff[(k+2)%3]) * PROD_BITS'(ap_ff[(k+1)%3]);
      end
      ab2_ff <= ab_ff; ac2_ff <= ac_ff; qp2_ff <= qp_ff; ap2_ff <= ap_ff;
   end

   // Stage 3: cross product components.
   logic      v3_ff;
   cross_type n_ff [3], e_ff [3];
   diff_type  ab3_ff [3], ac3_ff [3], qp3_ff [3], ap3_ff [3];
   always_ff @(posedge clock) begin
      v3_ff <= reset ? 1'b0 : v2_ff;
      for (int k = 0; k < 3; k++) begin
         n_ff[k] <= CROSS_BITS'(np_ff[2*k]) - CROSS_BITS'(np_ff[2*k+1]);
         e_ff[k] <= CROSS_BITS'(ep_ff[2*k]) - CROSS_BITS'(ep_ff[2*k+1]);
      end
      ab3_ff <= ab2_ff; ac3_ff <= ac2_ff; qp3_ff <= qp2_ff; ap3_ff <= ap2_ff;
   end

   // Stage 4: partial products of the four dot products d, t, v and (ab . e).
   // Each cross component is split into a zero-extended low half and a signed
   // high half, so every multiplier stays near 25 by 26 bits.
   logic signed [LO_BITS:0]   n_lo [3], e_lo [3];
   logic signed [HI_BITS-1:0] n_hi [3], e_hi [3];
   always_comb begin
      for (int k = 0; k < 3; k++) begin
         n_lo[k] = {1'b0, n_ff[k][LO_BITS-1:0]};
         e_lo[k] = {1'b0, e_ff[k][LO_BITS-1:0]};
         n_hi[k] = n_ff[k][CROSS_BITS-1:LO_BITS];
         e_hi[k] = e_ff[k][CROSS_BITS-1:LO_BITS];
      end
   end

   logic     v4_ff;
   part_type dl_ff [3], dh_ff [3], tl_ff [3], th_ff [3];
   part_type vl_ff [3], vh_ff [3], wl_ff [3], wh_ff [3];
   always_ff @(posedge clock) begin
      v4_ff <= reset ? 1'b0 : v3_ff;
      for (int k = 0; k < 3; k++) begin
         dl_ff[k] <= PART_BITS'(qp3_ff[k]) * PART_BITS'(n_lo[k]);
         dh_ff[k] <= PART_BITS'(qp3_ff[k]) * PART_BITS'(n_hi[k]);
         tl_ff[k] <= PART_BITS'(ap3_ff[k]) * PART_BITS'(n_lo[k]);
         th_ff[k] <= PART_BITS'(ap3_ff[k]) * PART_BITS'(n_hi[k]);
         vl_ff[k] <= PART_BITS'(ac3_ff[k]) * PART_BITS'(e_lo[k]);
         vh_ff[k] <= PART_BITS'(ac3_ff[k]) * PART_BITS'(e_hi[k]);
         wl_ff[k] <= PART_BITS'(ab3_ff[k]) * PART_BITS'(e_lo[k]);
         wh_ff[k] <= PART_BITS'(ab3_ff[k]) * PART_BITS'(e_hi[k]);
      end
   end

   // Stage 5: recombine the halves into the full terms of each dot product.
   logic     v5_ff;
   term_type dt_ff [3], tt_ff [3], vt_ff [3], wt_ff [3];
   always_ff @(posedge clock) begin
      v5_ff <= reset ? 1'b0 : v4_ff;
      for (int k = 0; k < 3; k++) begin
         dt_ff[k] <= (TERM_BITS'(dh_ff[k]) <<< LO_BITS) + TERM_BITS'(dl_ff[k]);
         tt_ff[k] <= (TERM_BITS'(th_ff[k]) <<< LO_BITS) + TERM_BITS'(tl_ff[k]);
         vt_ff[k] <= (TERM_BITS'(vh_ff[k]) <<< LO_BITS) + TERM_BITS'(vl_ff[k]);
         wt_ff[k] <= (TERM_BITS'(wh_ff[k]) <<< LO_BITS) + TERM_BITS'(wl_ff[k]);
      end
   end

   // Stage 6: sum the dot products; w is the negated (ab . e).
   logic    v6_ff;
   dot_type d_ff, t_ff, vv_ff, w_ff;
   always_ff @(posedge clock) begin
      v6_ff <= reset ? 1'b0 : v5_ff;
      d_ff  <= DOT_BITS'(dt_ff[0]) + DOT_BITS'(dt_ff[1]) + DOT_BITS'(dt_ff[2]);
      t_ff  <= DOT_BITS'(tt_ff[0]) + DOT_BITS'(tt_ff[1]) + DOT_BITS'(tt_ff[2]);
      vv_ff <= DOT_BITS'(vt_ff[0]) + DOT_BITS'(vt_ff[1]) + DOT_BITS'(vt_ff[2]);
      w_ff  <= -(DOT_BITS'(wt_ff[0]) + DOT_BITS'(wt_ff[1]) + DOT_BITS'(wt_ff[2]));
   end

   // Stage 7: classify in the order backface, plane, outside and seed the divider.
   div_stage_type div_in_ff, div_out;
   logic signed [DOT_BITS:0] vw_sum;
   logic [1:0] cause;
   assign vw_sum = (DOT_BITS+1)'(vv_ff) + (DOT_BITS+1)'(w_ff);

   always_comb begin
      priority if (d_ff <= 0) begin
         cause = CAUSE_BACKFACE;
      end else if (t_ff < 0 || t_ff > d_ff) begin
         cause = CAUSE_PLANE;
      end else if (vv_ff < 0 || vv_ff > d_ff || w_ff < 0
                   || vw_sum > (DOT_BITS+1)'(d_ff)) begin
         cause = CAUSE_OUTSIDE;
      end else begin
         cause = CAUSE_HIT;
      end
   end

   always_ff @(posedge clock) begin
      div_in_ff.valid <= reset ? 1'b0 : v6_ff;
      div_in_ff.hit   <= (cause == CAUSE_HIT);
      div_in_ff.cause <= cause;
      div_in_ff.quot  <= '0;
      div_in_ff.rem   <= REM_BITS'(t_ff);
      div_in_ff.den   <= d_ff;
   end

   sti_divider u_divider (
      .clock     (clock),
      .reset     (reset),
      .in_stage  (div_in_ff),
      .out_stage (div_out)
   );

   assign rsp_valid             = div_out.valid;
   assign rsp_data.hit          = div_out.hit;
   assign rsp_data.hit_fraction = div_out.hit ? div_out.quot : '0;
   assign rsp_data.miss_cause   = div_out.cause;

   `STI_ASSERT_IMPLY(a_hit_cause, clock, reset, rsp_valid,
      rsp_data.hit == (rsp_data.miss_cause == CAUSE_HIT), "hit and cause disagree")
   `STI_ASSERT_IMPLY(a_miss_zero, clock, reset, rsp_valid && !rsp_data.hit,
      rsp_data.hit_fraction == '0, "miss with nonzero fraction")
   `STI_ASSERT_NEXT(a_seed, clock, reset, v6_ff, div_in_ff.valid,
      "divider seed lost a beat")
endmodule
`default_nettype wire

### rtl/sti_divider.sv
// Pipelined restoring divider, one quotient bit per stage.
`default_nettype none
module sti_divider
   import sti_pkg::*;
(
   input  wire                clock,
   input  wire                reset,
   input  wire div_stage_type in_stage,
   output div_stage_type      out_stage
);
   div_stage_type stage_ff [FRAC_W];
   div_stage_type stage_in [FRAC_W];

   always_comb begin
      for (int i = 0; i < FRAC_W; i++) begin
         div_stage_type prev;
         logic signed [REM_BITS-1:0] r;
         prev = (i == 0) ? in_stage : stage_ff[i-1];
         r = (i == 0) ? prev.rem : (prev.rem <<< 1);
         stage_in[i] = prev;
         stage_in[i].valid = prev.valid && !reset;
         stage_in[i].rem = r;
         stage_in[i].quot = prev.quot << 1;
         if (r >= REM_BITS'(prev.den)) begin
            stage_in[i].rem = r - REM_BITS'(prev.den);
            stage_in[i].quot[0] = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      for (int i = 0; i < FRAC_W; i++) begin
         stage_ff[i] <= stage_in[i];
      end
   end

   assign out_stage = stage_ff[FRAC_W-1];
endmodule
`default_nettype wire
